### hw/rtl/line_segment_clipper_top_macros.svh
// Assertion macros for the line segment clipper RTL.
`ifndef LINE_SEGMENT_CLIPPER_TOP_MACROS_SVH
`define LINE_SEGMENT_CLIPPER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/lsc_pkg.sv
// Shared constants and types for the line segment clipper.
package lsc_pkg;

  // Default coordinate width.
  localparam int COORD_BITS_DEF = 12;

  // Upper bound on clipping rounds for one item.
  localparam int MAX_ROUNDS = 16;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_LEFT  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_RIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_YMAX  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_YMIN  = 2'd3;

  // Region outcode of one endpoint.
  typedef struct packed {
    logic bottom;
    logic right;
    logic top;
    logic left;
  } outcode_t;

endpackage

### hw/rtl/line_segment_clipper_top.sv
// Cohen-Sutherland segment clipper with a shared multiply and serial divider.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_stall    in_start_x, in_start_y, in_end_x, in_end_y
//   out      output     out_valid/out_stall  out_accepted, out_clip_start_x/y,
//                                            out_clip_end_x/y
//   cfg      input      cfg_we               cfg_index, cfg_wdata
//
// From acceptance to its result an item goes through its clipping rounds:
// at most four for a proper rectangle and up to MAX_ROUNDS (16) when the
// rectangle is inverted.
// Each round is one outcode check, one multiply, COORD_BITS restoring divide
// steps of the one-bit-per-cycle divider and one endpoint update.
// Reset is synchronous and active low and clears the clip rectangle to full range.
// A new item is taken while the previous result still waits under out_stall;
// a finished item waits in its check step only if that result is still held.
module line_segment_clipper_top #(
  parameter int COORD_BITS = lsc_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [COORD_BITS-1:0]           in_start_x,
  input  logic [COORD_BITS-1:0]           in_start_y,
  input  logic [COORD_BITS-1:0]           in_end_x,
  input  logic [COORD_BITS-1:0]           in_end_y,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_accepted,
  output logic [COORD_BITS-1:0]           out_clip_start_x,
  output logic [COORD_BITS-1:0]           out_clip_start_y,
  output logic [COORD_BITS-1:0]           out_clip_end_x,
  output logic [COORD_BITS-1:0]           out_clip_end_y,
  // Configuration port
  input  logic                            cfg_we,
  input  logic [lsc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]           cfg_wdata
);

`include "line_segment_clipper_top_macros.svh"

  localparam int N      = COORD_BITS;
  localparam int CntW   = $clog2(N);
  localparam int RoundW = $clog2(lsc_pkg::MAX_ROUNDS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;

  // Outcode of one point against the current rectangle.
  function automatic lsc_pkg::outcode_t region_code(
    input logic [N-1:0] x, input logic [N-1:0] y,
    input logic [N-1:0] left, input logic [N-1:0] right,
    input logic [N-1:0] ymax, input logic [N-1:0] ymin
  );
    lsc_pkg::outcode_t c;
    c.left   = (x < left);
    c.right  = !(x < left) && (x > right);
    c.top    = (y > ymax);
    c.bottom = !(y > ymax) && (y < ymin);
    return c;
  endfunction

  logic [2:0]        state_r, state_nxt;
  logic [N-1:0]      clip_left_r, clip_right_r, clip_ymax_r, clip_ymin_r;
  logic [N-1:0]      ax_r, ay_r, bx_r, by_r;
  logic [N-1:0]      ax_nxt, ay_nxt, bx_nxt, by_nxt;
  logic [N-1:0]      edge_r, edge_nxt;
  logic              sel_x_r, sel_x_nxt;
  logic              move_b_r, move_b_nxt;
  logic [RoundW-1:0] rounds_r, rounds_nxt;
  logic [N-1:0]      rem_r, rem_nxt;
  logic [N-1:0]      num_lo_r, num_lo_nxt;
  logic [N-1:0]      quo_r, quo_nxt;
  logic [N-1:0]      den_r, den_nxt;
  logic              neg_r, neg_nxt;
  logic              den_zero_r, den_zero_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_acc_r, out_acc_nxt;
  logic [N-1:0]      out_sx_r, out_sy_r, out_ex_r, out_ey_r;
  logic [N-1:0]      out_sx_nxt, out_sy_nxt, out_ex_nxt, out_ey_nxt;

  lsc_pkg::outcode_t ca, cb, csel;
  logic [3:0]        code_or, code_and;
  logic              finish, all_in, out_free, in_take;

  logic signed [N:0]     t_s, m_s, d_s;
  logic signed [2*N+1:0] prod_s, prod_abs;
  logic signed [N:0]     d_abs;

  logic [N:0]            cand;
  logic [N:0]            diff;
  logic                  fits;

  logic signed [N+1:0]   q_s, new_s;
  logic [N-1:0]          base, new_c;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r  <= '0;
      clip_right_r <= '1;
      clip_ymax_r  <= '1;
      clip_ymin_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsc_pkg::REG_CLIP_LEFT:  clip_left_r  <= cfg_wdata;
        lsc_pkg::REG_CLIP_RIGHT: clip_right_r <= cfg_wdata;
        lsc_pkg::REG_CLIP_YMAX:  clip_ymax_r  <= cfg_wdata;
        lsc_pkg::REG_CLIP_YMIN:  clip_ymin_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Outcodes and the stop test for the current endpoints.
  always_comb begin
    ca       = region_code(ax_r, ay_r, clip_left_r, clip_right_r, clip_ymax_r, clip_ymin_r);
    cb       = region_code(bx_r, by_r, clip_left_r, clip_right_r, clip_ymax_r, clip_ymin_r);
    code_or  = ca | cb;
    code_and = ca & cb;
    all_in   = (code_or == 4'd0);
    finish   = all_in || (code_and != 4'd0) ||
               (rounds_r == RoundW'(lsc_pkg::MAX_ROUNDS));
    csel     = (ca != 4'd0) ? ca : cb;
    out_free = !out_valid_r || !out_stall;
    in_take  = (state_r == ST_IDLE) && in_valid;
  end

  // Shared multiplier: numerator and divisor of the intersection.
  always_comb begin
    if (sel_x_r) begin
      t_s = $signed({1'b0, edge_r}) - $signed({1'b0, ax_r});
      m_s = $signed({1'b0, by_r}) - $signed({1'b0, ay_r});
      d_s = $signed({1'b0, bx_r}) - $signed({1'b0, ax_r});
    end else begin
      t_s = $signed({1'b0, edge_r}) - $signed({1'b0, ay_r});
      m_s = $signed({1'b0, bx_r}) - $signed({1'b0, ax_r});
      d_s = $signed({1'b0, by_r}) - $signed({1'b0, ay_r});
    end
    prod_s   = t_s * m_s;
    prod_abs = prod_s[2*N+1] ? -prod_s : prod_s;
    d_abs    = d_s[N] ? -d_s : d_s;
  end

  // One restoring divide step.
  always_comb begin
    cand = {rem_r, num_lo_r[N-1]};
    diff = cand - {1'b0, den_r};
    fits = (cand >= {1'b0, den_r});
  end

  // Floor correction and the new endpoint coordinate.
  always_comb begin
    if (den_zero_r) begin
      q_s = '0;
    end else if (neg_r) begin
      q_s = -$signed({2'b00, quo_r}) - $signed({{(N+1){1'b0}}, (rem_r != '0)});
    end else begin
      q_s = $signed({2'b00, quo_r});
    end
    base  = sel_x_r ? ay_r : ax_r;
    new_s = $signed({2'b00, base}) + q_s;
    new_c = new_s[N-1:0];
  end

  // Sequencer and datapath next state.
  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    edge_nxt      = edge_r;
    sel_x_nxt     = sel_x_r;
    move_b_nxt    = move_b_r;
    rounds_nxt    = rounds_r;
    rem_nxt       = rem_r;
    num_lo_nxt    = num_lo_r;
    quo_nxt       = quo_r;
    den_nxt       = den_r;
    neg_nxt       = neg_r;
    den_zero_nxt  = den_zero_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_acc_nxt   = out_acc_r;
    out_sx_nxt    = out_sx_r;
    out_sy_nxt    = out_sy_r;
    out_ex_nxt    = out_ex_r;
    out_ey_nxt    = out_ey_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          ax_nxt     = in_start_x;
          ay_nxt     = in_start_y;
          bx_nxt     = in_end_x;
          by_nxt     = in_end_y;
          rounds_nxt = '0;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (finish) begin
          // Deliver once the output register is free.
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_acc_nxt   = all_in;
            out_sx_nxt    = all_in ? ax_r : '0;
            out_sy_nxt    = all_in ? ay_r : '0;
            out_ex_nxt    = all_in ? bx_r : '0;
            out_ey_nxt    = all_in ? by_r : '0;
            state_nxt     = ST_IDLE;
          end
        end else begin
          // Pick the endpoint and edge: left, top, right, bottom.
          move_b_nxt = (ca == 4'd0);
          sel_x_nxt  = csel.left || (!csel.top && csel.right);
          if (csel.left) begin
            edge_nxt = clip_left_r;
          end else if (csel.top) begin
            edge_nxt = clip_ymax_r;
          end else if (csel.right) begin
            edge_nxt = clip_right_r;
          end else begin
            edge_nxt = clip_ymin_r;
          end
          rounds_nxt = rounds_r + RoundW'(1);
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        // Load the divider with magnitudes; the quotient fits in N bits.
        rem_nxt      = prod_abs[2*N-1:N];
        num_lo_nxt   = prod_abs[N-1:0];
        den_nxt      = d_abs[N-1:0];
        neg_nxt      = prod_s[2*N+1] ^ d_s[N];
        den_zero_nxt = (d_s == '0);
        quo_nxt      = '0;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt    = fits ? diff[N-1:0] : cand[N-1:0];
        quo_nxt    = {quo_r[N-2:0], fits};
        num_lo_nxt = {num_lo_r[N-2:0], 1'b0};
        cnt_nxt    = cnt_r + CntW'(1);
        if (cnt_r == CntW'(N - 1)) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (move_b_r) begin
          bx_nxt = sel_x_r ? edge_r : new_c;
          by_nxt = sel_x_r ? new_c : edge_r;
        end else begin
          ax_nxt = sel_x_r ? edge_r : new_c;
          ay_nxt = sel_x_r ? new_c : edge_r;
        end
        state_nxt = ST_CHECK;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rounds_r    <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rounds_r    <= rounds_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    bx_r       <= bx_nxt;
    by_r       <= by_nxt;
    edge_r     <= edge_nxt;
    sel_x_r    <= sel_x_nxt;
    move_b_r   <= move_b_nxt;
    rem_r      <= rem_nxt;
    num_lo_r   <= num_lo_nxt;
    quo_r      <= quo_nxt;
    den_r      <= den_nxt;
    neg_r      <= neg_nxt;
    den_zero_r <= den_zero_nxt;
    out_acc_r  <= out_acc_nxt;
    out_sx_r   <= out_sx_nxt;
    out_sy_r   <= out_sy_nxt;
    out_ex_r   <= out_ex_nxt;
    out_ey_r   <= out_ey_nxt;
  end

  // Port drive.
  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_accepted     = out_acc_r;
  assign out_clip_start_x = out_sx_r;
  assign out_clip_start_y = out_sy_r;
  assign out_clip_end_x   = out_ex_r;
  assign out_clip_end_y   = out_ey_r;

  // Checks on the sequencer and the result.
  `LSC_ASSERT_NEXT(a_item_starts_check, clk, rst_n, in_valid && !in_stall, state_r == ST_CHECK, "accepted item did not enter the check step")
  `LSC_ASSERT_IMPL(a_reject_zero, clk, rst_n, out_valid && !out_accepted, (out_clip_start_x | out_clip_start_y | out_clip_end_x | out_clip_end_y) == '0, "rejected result carries nonzero coordinates")
  `LSC_ASSERT_NEXT(a_div_ends, clk, rst_n, state_r == ST_DIV && cnt_r == CntW'(N - 1), state_r == ST_UPD, "divider did not hand over to the update step")
  `LSC_ASSERT_IMPL(a_round_bound, clk, rst_n, state_r != ST_IDLE, rounds_r <= RoundW'(lsc_pkg::MAX_ROUNDS), "round count ran past its limit")

endmodule

### dv/tb_line_segment_clipper_top.sv
// Self-checking testbench for the Cohen-Sutherland line segment clipper.
module tb_line_segment_clipper_top;

  localparam int CW = lsc_pkg::COORD_BITS_DEF;
  localparam int CMAX = (1 << CW) - 1;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
  } segment_t;

  typedef struct {
    logic          accepted;
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
  } clipped_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CW-1:0] in_start_x = '0;
  logic [CW-1:0] in_start_y = '0;
  logic [CW-1:0] in_end_x = '0;
  logic [CW-1:0] in_end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_accepted;
  logic [CW-1:0] out_clip_start_x;
  logic [CW-1:0] out_clip_start_y;
  logic [CW-1:0] out_clip_end_x;
  logic [CW-1:0] out_clip_end_y;
  logic cfg_we = 1'b0;
  logic [lsc_pkg::CFG_IDX_BITS-1:0] cfg_index = lsc_pkg::REG_CLIP_LEFT;
  logic [CW-1:0] cfg_wdata = '0;

  // Mirror of the clip window; it only changes while the block is idle.
  longint win_left = 0;
  longint win_right = CMAX;
  longint win_ymax = CMAX;
  longint win_ymin = 0;

  segment_t pending_segments[$];
  clipped_t expected_clips[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  line_segment_clipper_top #(.COORD_BITS(CW)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_accepted(out_accepted),
    .out_clip_start_x(out_clip_start_x), .out_clip_start_y(out_clip_start_y),
    .out_clip_end_x(out_clip_end_x), .out_clip_end_y(out_clip_end_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic note_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Outcode of one point against the current window; left wins over right and
  // top over bottom, which matters for an inverted window.
  function automatic lsc_pkg::outcode_t region_of(longint x, longint y);
    lsc_pkg::outcode_t oc;
    oc = '0;
    if (x < win_left) oc.left = 1'b1;
    else if (x > win_right) oc.right = 1'b1;
    if (y > win_ymax) oc.top = 1'b1;
    else if (y < win_ymin) oc.bottom = 1'b1;
    return oc;
  endfunction

  // Quotient rounded toward minus infinity; a zero divisor gives zero.
  function automatic longint floor_div(longint num, longint den);
    longint q;
    if (den == 0) return 0;
    q = num / den;
    if ((num % den != 0) && ((num < 0) != (den < 0))) q = q - 1;
    return q;
  endfunction

  function automatic clipped_t clip_segment(segment_t seg);
    longint ax, ay, bx, by, nx, ny, e;
    lsc_pkg::outcode_t ca, cb, c;
    int rounds;
    clipped_t r;
    ax = seg.sx;
    ay = seg.sy;
    bx = seg.ex;
    by = seg.ey;
    ca = region_of(ax, ay);
    cb = region_of(bx, by);
    rounds = 0;
    while ((ca | cb) != 0 && (ca & cb) == 0 && rounds < lsc_pkg::MAX_ROUNDS) begin
      c = (ca != 0) ? ca : cb;
      rounds++;
      // Edges are taken in the order left, top, right, bottom.
      if (c.left || (c.right && !c.top)) begin
        e = c.left ? win_left : win_right;
        nx = e;
        ny = ay + floor_div((e - ax) * (by - ay), bx - ax);
      end else begin
        e = c.top ? win_ymax : win_ymin;
        ny = e;
        nx = ax + floor_div((e - ay) * (bx - ax), by - ay);
      end
      if (ca != 0) begin
        ax = nx;
        ay = ny;
        ca = region_of(ax, ay);
      end else begin
        bx = nx;
        by = ny;
        cb = region_of(bx, by);
      end
    end
    if (ca == 0 && cb == 0) begin
      r.accepted = 1'b1;
      r.sx = CW'(ax);
      r.sy = CW'(ay);
      r.ex = CW'(bx);
      r.ey = CW'(by);
    end else begin
      r = '{1'b0, '0, '0, '0, '0};
    end
    return r;
  endfunction

  // Input driver: a new item is offered only after the last one was taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_clips.push_back(clip_segment('{in_start_x, in_start_y, in_end_x, in_end_y}));
      if (!in_valid || !in_stall) begin
        if (pending_segments.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          segment_t seg;
          seg = pending_segments.pop_front();
          in_start_x <= seg.sx;
          in_start_y <= seg.sy;
          in_end_x <= seg.ex;
          in_end_y <= seg.ey;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each taken result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_clips.size() == 0) begin
        note_mismatch("result with no segment outstanding");
      end else begin
        clipped_t want;
        want = expected_clips.pop_front();
        if (out_accepted !== want.accepted)
          note_mismatch($sformatf("accepted %0b, expected %0b", out_accepted, want.accepted));
        if (out_clip_start_x !== want.sx)
          note_mismatch($sformatf("clip_start_x %0d, expected %0d", out_clip_start_x, want.sx));
        if (out_clip_start_y !== want.sy)
          note_mismatch($sformatf("clip_start_y %0d, expected %0d", out_clip_start_y, want.sy));
        if (out_clip_end_x !== want.ex)
          note_mismatch($sformatf("clip_end_x %0d, expected %0d", out_clip_end_x, want.ex));
        if (out_clip_end_y !== want.ey)
          note_mismatch($sformatf("clip_end_y %0d, expected %0d", out_clip_end_y, want.ey));
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL line_segment_clipper_top");
      $finish;
    end
  end

  task automatic add_segment(int sx, int sy, int ex, int ey);
    pending_segments.push_back('{CW'(sx), CW'(sy), CW'(ex), CW'(ey)});
  endtask

  // Wait until every item was taken and every result came back; the test runs
  // on the falling edge so that the driver's updates have settled.
  task automatic wait_idle();
    while (pending_segments.size() > 0 || in_valid || expected_clips.size() > 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_window(int left, int right, int ymax, int ymin);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= lsc_pkg::REG_CLIP_LEFT;
    cfg_wdata <= CW'(left);
    @(posedge clk);
    cfg_index <= lsc_pkg::REG_CLIP_RIGHT;
    cfg_wdata <= CW'(right);
    @(posedge clk);
    cfg_index <= lsc_pkg::REG_CLIP_YMAX;
    cfg_wdata <= CW'(ymax);
    @(posedge clk);
    cfg_index <= lsc_pkg::REG_CLIP_YMIN;
    cfg_wdata <= CW'(ymin);
    @(posedge clk);
    cfg_we <= 1'b0;
    win_left = left;
    win_right = right;
    win_ymax = ymax;
    win_ymin = ymin;
    @(posedge clk);
  endtask

  // A coordinate that is uniform, near one of two window edges, or between them.
  function automatic int pick_coord(longint lo, longint hi);
    int v;
    case ($urandom_range(3))
      0: v = $urandom_range(CMAX);
      1: v = int'(lo) + $urandom_range(8) - 4;
      2: v = int'(hi) + $urandom_range(8) - 4;
      default: v = (lo <= hi) ? $urandom_range(int'(hi), int'(lo))
                              : $urandom_range(int'(lo), int'(hi));
    endcase
    if (v < 0) v = 0;
    if (v > CMAX) v = CMAX;
    return v;
  endfunction

  task automatic add_random_segments(int count);
    repeat (count)
      add_segment(pick_coord(win_left, win_right), pick_coord(win_ymin, win_ymax),
                  pick_coord(win_left, win_right), pick_coord(win_ymin, win_ymax));
  endtask

  initial begin
    int l, r, b, t;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 13;
    recv_idle_pct = 65;

    // Full-range window after reset: every segment passes unchanged.
    add_segment(0, 0, CMAX, CMAX);
    add_segment(CMAX, CMAX, 0, 0);
    add_segment(0, CMAX, CMAX, 0);
    add_segment(2048, 2048, 2048, 2048);
    wait_idle();

    // Directed cases against an inner window.
    set_window(1000, 3000, 3500, 500);
    add_segment(1500, 1000, 2500, 3000);   // fully inside
    add_segment(100, 1000, 900, 3000);     // rejected on the left
    add_segment(3100, 600, CMAX, 3400);    // rejected on the right
    add_segment(1200, 3600, 2800, CMAX);   // rejected above
    add_segment(1200, 0, 2800, 499);       // rejected below
    add_segment(0, 2000, 2000, 2100);      // crosses the left edge
    add_segment(2000, 2000, 2100, CMAX);   // crosses the top edge
    add_segment(2000, 2000, CMAX, 1000);   // crosses the right edge
    add_segment(1500, 3000, 1600, 0);      // crosses the bottom edge
    add_segment(0, 0, CMAX, CMAX);         // both ends outside, through the window
    add_segment(CMAX, 0, 0, CMAX);
    add_segment(800, 400, 1100, 0);        // shared bottom bit
    add_segment(0, 3400, 1200, CMAX);      // passes outside a corner
    add_segment(1000, 0, 1000, CMAX);      // vertical on the left edge
    add_segment(0, 500, CMAX, 500);        // horizontal on the bottom edge
    add_segment(CMAX, CMAX, CMAX, CMAX);   // single point outside
    add_segment(3000, 3500, 3000, 3500);   // single point on a corner
    add_segment(999, 501, 3001, 3499);     // intersections that round down
    add_segment(3001, 499, 999, 3501);
    wait_idle();

    // Random window, sender rarely idle and receiver often stalled.
    l = $urandom_range(CMAX);
    r = $urandom_range(CMAX, l);
    b = $urandom_range(CMAX);
    t = $urandom_range(CMAX, b);
    set_window(l, r, t, b);
    add_random_segments(450);
    wait_idle();

    // Narrow window, sender often idle and receiver rarely stalled.
    send_idle_pct = 65;
    recv_idle_pct = 13;
    l = $urandom_range(CMAX - 8);
    b = $urandom_range(CMAX - 8);
    set_window(l, l + $urandom_range(8), b + $urandom_range(8), b);
    add_random_segments(450);
    wait_idle();

    // Inverted window: nothing can be inside, so every segment is rejected.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_window(3000, 1000, 800, 2500);
    add_random_segments(150);
    wait_idle();

    l = $urandom_range(CMAX);
    r = $urandom_range(CMAX, l);
    b = $urandom_range(CMAX);
    t = $urandom_range(CMAX, b);
    set_window(l, r, t, b);
    add_random_segments(450);
    wait_idle();

    // Window collapsed onto the extreme corner of the coordinate range.
    set_window(CMAX, CMAX, 0, 0);
    add_random_segments(350);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("PASS line_segment_clipper_top");
    else
      $display("FAIL line_segment_clipper_top");
    $finish;
  end

endmodule
